[hdl/jst_pkg.sv]
`timescale 1ns / 1ps
package jst_pkg;

    localparam int MaxNestDefault   = 16;
    localparam int MaxDigitsDefault = 18;

    localparam logic [15:0] BudgetReset   = 16'd1024;
    localparam logic [8:0]  ContLimReset  = 9'd256;
    localparam logic [18:0] InLimReset    = 19'd262144;

    typedef enum logic [1:0] {
        REG_VALUE_BUDGET    = 2'd0,
        REG_CONTAINER_LIMIT = 2'd1,
        REG_INPUT_LIMIT     = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        K_OBJ_START = 4'd0,
        K_OBJ_END   = 4'd1,
        K_ARR_START = 4'd2,
        K_ARR_END   = 4'd3,
        K_KEY_BYTE  = 4'd4,
        K_KEY_END   = 4'd5,
        K_STR_BYTE  = 4'd6,
        K_STR_END   = 4'd7,
        K_INT       = 4'd8,
        K_TRUE      = 4'd9,
        K_FALSE     = 4'd10,
        K_NULL      = 4'd11,
        K_DONE      = 4'd12,
        K_ERROR     = 4'd13
    } kind_t;

    typedef enum logic [4:0] {
        E_BAD_LIT      = 5'd0,
        E_EXP_STRING   = 5'd1,
        E_TRUNC_ESC    = 5'd2,
        E_TRUNC_U      = 5'd3,
        E_BAD_HEX      = 5'd4,
        E_NUL_ESC      = 5'd5,
        E_SURROGATE    = 5'd6,
        E_UNK_ESC      = 5'd7,
        E_CTRL_CHAR    = 5'd8,
        E_UNTERM_STR   = 5'd9,
        E_TOO_DEEP     = 5'd10,
        E_TOO_MANY_VAL = 5'd11,
        E_UNEXP_END    = 5'd12,
        E_EXP_COLON    = 5'd13,
        E_OBJ_FULL     = 5'd14,
        E_EXP_COMMA_OB = 5'd15,
        E_ARR_FULL     = 5'd16,
        E_EXP_COMMA_AR = 5'd17,
        E_BAD_NUM      = 5'd18,
        E_NUM_LONG     = 5'd19,
        E_FLOAT        = 5'd20,
        E_UNEXP_CHAR   = 5'd21,
        E_TOO_LARGE    = 5'd22,
        E_TRAILING     = 5'd23
    } err_t;

    typedef enum logic [4:0] {
        M_TOP       = 5'd0,
        M_VALUE     = 5'd1,
        M_ARR_FIRST = 5'd2,
        M_ARR_NEXT  = 5'd3,
        M_OBJ_FIRST = 5'd4,
        M_KEY       = 5'd5,
        M_OBJ_NEXT  = 5'd6,
        M_COLON     = 5'd7,
        M_STR       = 5'd8,
        M_STR_ESC   = 5'd9,
        M_STR_HEX   = 5'd10,
        M_KSTR      = 5'd11,
        M_KSTR_ESC  = 5'd12,
        M_KSTR_HEX  = 5'd13,
        M_NUM_SIGN  = 5'd14,
        M_NUM       = 5'd15,
        M_LIT_T     = 5'd16,
        M_LIT_F     = 5'd17,
        M_LIT_N     = 5'd18,
        M_AFTER     = 5'd19
    } mode_t;

    // classified byte handed from front to back
    typedef struct packed {
        logic        is_end;
        logic [7:0]  data;
        logic [18:0] pos;
        logic        over;      // byte beyond input limit
        logic        is_ws;
        logic        is_digit;
        logic [3:0]  digit;
        logic        hex_ok;
        logic [3:0]  hex;
    } tok_t;

    // one result event
    typedef struct packed {
        logic [3:0]         kind;
        logic [7:0]         text_byte;
        logic signed [60:0] int_value;
        logic [4:0]         nest_depth;
        logic [4:0]         error_code;
        logic [18:0]        byte_offset;
        logic               last_of_run;
    } evt_t;

    // literal letter at a position
    function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] p);
        logic [7:0] c;
        begin
            c = 8'h00;
            unique case (w)
                2'd0: c = (p == 3'd0) ? "t" : (p == 3'd1) ? "r" : (p == 3'd2) ? "u" :
                          (p == 3'd3) ? "e" : 8'h00;
                2'd1: c = (p == 3'd0) ? "f" : (p == 3'd1) ? "a" : (p == 3'd2) ? "l" :
                          (p == 3'd3) ? "s" : (p == 3'd4) ? "e" : 8'h00;
                2'd2: c = (p == 3'd0) ? "n" : (p == 3'd1) ? "u" : (p == 3'd2) ? "l" :
                          (p == 3'd3) ? "l" : 8'h00;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] w);
        begin
            return (w == 2'd1) ? 3'd5 : 3'd4;
        end
    endfunction

endpackage

[hdl/jst_if.sv]
`timescale 1ns / 1ps
interface jst_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface jst_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         kind;
    logic [7:0]         text_byte;
    logic signed [60:0] int_value;
    logic [4:0]         nest_depth;
    logic [4:0]         error_code;
    logic [18:0]        byte_offset;
    logic               last_of_run;
    modport source (output valid, output kind, output text_byte, output int_value,
                    output nest_depth, output error_code, output byte_offset,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input text_byte, input int_value,
                    input nest_depth, input error_code, input byte_offset,
                    input last_of_run, output ready);
endinterface

interface jst_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [18:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/jst_front.sv]
`timescale 1ns / 1ps
module jst_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_cmd,
    input  logic [7:0]      in_data,
    input  logic [18:0]     input_limit,
    output logic            q_push,
    output jst_pkg::tok_t   q_data,
    input  logic            q_full
);
    import jst_pkg::*;

    logic [18:0] pos_reg, pos_next;
    logic        acc;
    logic        over;

    assign in_ready = !q_full;
    assign acc      = in_valid && in_ready;
    assign over     = (pos_reg >= input_limit);

    // byte position, cleared at document end
    always_comb
    begin
        pos_next = pos_reg;
        if (acc)
        begin
            if (in_cmd)
                pos_next = '0;
            else if (!over)
                pos_next = pos_reg + 19'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    // byte classification
    always_comb
    begin
        q_push          = acc;
        q_data.is_end   = in_cmd;
        q_data.data     = in_data;
        q_data.pos      = pos_reg;
        q_data.over     = over;
        q_data.is_ws    = (in_data == 8'h20) || (in_data == 8'h09) ||
                          (in_data == 8'h0A) || (in_data == 8'h0D);
        q_data.is_digit = (in_data >= "0") && (in_data <= "9");
        q_data.digit    = in_data[3:0];
        q_data.hex_ok   = 1'b1;
        q_data.hex      = in_data[3:0];
        if ((in_data >= "0") && (in_data <= "9"))
            q_data.hex = in_data[3:0];
        else if (((in_data >= "a") && (in_data <= "f")) ||
                 ((in_data >= "A") && (in_data <= "F")))
            q_data.hex = in_data[3:0] + 4'd9;
        else
            q_data.hex_ok = 1'b0;
    end
endmodule

[hdl/jst_queue.sv]
`timescale 1ns / 1ps
module jst_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jst_pkg::tok_t   wdata,
    output logic            full,
    input  logic            pop,
    output jst_pkg::tok_t   rdata,
    output logic            empty
);
    import jst_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tok_t            mem [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;

    assign full  = (cnt_reg == (AW + 1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rp_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wp_reg] <= wdata;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop && !empty)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW + 1)'(push && !full) - (AW + 1)'(pop && !empty);
        end
    end
endmodule

[hdl/jst_back.sv]
`timescale 1ns / 1ps
module jst_back #(
    parameter int MAX_NEST   = 16,
    parameter int MAX_DIGITS = 18
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  jst_pkg::tok_t   q_data,
    output logic            q_pop,
    input  logic [15:0]     value_budget,
    input  logic [8:0]      container_limit,
    output logic            out_valid,
    input  logic            out_ready,
    output jst_pkg::evt_t   out_evt
);
    import jst_pkg::*;

    localparam int SD = MAX_NEST + 1;
    localparam int SW = $clog2(SD);

    // container stack, kept in flops, read at top of stack and, on a close, at the parent entry
    logic            ckind_reg [SD];
    logic [8:0]      ecnt_reg  [SD];

    mode_t           mode_reg, mode_next;
    logic [4:0]      lvl_reg, lvl_next;
    logic [59:0]     acc_reg, acc_next;
    logic [4:0]      dcnt_reg, dcnt_next;
    logic            neg_reg, neg_next;
    logic [15:0]     hex_reg, hex_next;
    logic [2:0]      hcnt_reg, hcnt_next;
    logic [2:0]      lp_reg, lp_next;
    logic [15:0]     vcnt_reg, vcnt_next;
    logic            fin_reg, fin_next;

    // output skid: up to three events per byte
    evt_t            ev_reg [3];
    logic [1:0]      evn_reg, evi_reg;
    evt_t            ev_next [3];
    logic [1:0]      evn_next;

    logic            wr_en, wr_kind;
    logic [SW-1:0]   wr_idx;
    logic [8:0]      wr_cnt;
    logic            top_kind;
    logic [8:0]      top_cnt;
    logic [SW-1:0]   top_idx;
    logic            busy;

    assign busy    = (evn_reg != 2'd0);
    assign q_pop   = !q_empty && (!busy || ((evi_reg + 2'd1 == evn_reg) && out_ready));
    assign out_valid = busy;
    assign out_evt   = ev_reg[evi_reg];

    assign top_idx  = SW'(lvl_reg - 5'd1);
    assign top_kind = ckind_reg[top_idx];
    assign top_cnt  = ecnt_reg[top_idx];

    // byte processing
    always_comb
    begin
        logic [7:0]  b;
        logic [18:0] pos;
        logic        stop;
        logic [1:0]  n;
        logic [4:0]  ld;
        logic [15:0] v;
        logic        k;
        logic [1:0]  w;
        logic [59:0] nv;

        mode_next = mode_reg;  lvl_next = lvl_reg;  acc_next = acc_reg;
        dcnt_next = dcnt_reg;  neg_next = neg_reg;  hex_next = hex_reg;
        hcnt_next = hcnt_reg;  lp_next = lp_reg;    vcnt_next = vcnt_reg;
        fin_next  = fin_reg;
        wr_en = 1'b0; wr_kind = 1'b0; wr_idx = '0; wr_cnt = '0;
        for (int i = 0; i < 3; i++)
            ev_next[i] = '0;
        n = 2'd0; stop = 1'b0;
        b = q_data.data; pos = q_data.pos;
        v = '0; k = 1'b0; w = 2'd0; nv = '0; ld = lvl_reg;

        if (q_pop)
        begin
            // generic emitters as inline blocks keyed on n
            if (q_data.is_end)
            begin
                if (!fin_reg)
                begin
                    if (mode_reg == M_TOP)
                    begin
                        if (lvl_reg > 5'(MAX_NEST))
                        begin
                            ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_TOO_DEEP, pos, 1'b0};
                            n = n + 2'd1; stop = 1'b1;
                        end
                        else if (vcnt_reg >= value_budget)
                        begin
                            ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_TOO_MANY_VAL, pos,
                                           1'b0};
                            n = n + 2'd1; stop = 1'b1;
                        end
                        else
                        begin
                            ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_UNEXP_END, pos, 1'b0};
                            n = n + 2'd1; stop = 1'b1;
                        end
                    end
                    else if (mode_reg == M_NUM)
                    begin
                        ev_next[n] = '{K_INT, 8'd0,
                                       neg_reg ? -$signed({1'b0, acc_reg}) :
                                                 $signed({1'b0, acc_reg}),
                                       ld, 5'd0, 19'd0, 1'b0};
                        n = n + 2'd1;
                        if (lvl_reg == 5'd0)
                        begin
                            ev_next[n] = '{K_DONE, 8'd0, 61'sd0, ld, 5'd0, 19'd0, 1'b0};
                            n = n + 2'd1;
                        end
                        else if (top_cnt >= container_limit)
                        begin
                            ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld,
                                           top_kind ? E_OBJ_FULL : E_ARR_FULL, pos, 1'b0};
                            n = n + 2'd1;
                        end
                        else
                        begin
                            ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld,
                                           top_kind ? E_EXP_COMMA_OB : E_EXP_COMMA_AR,
                                           pos, 1'b0};
                            n = n + 2'd1;
                        end
                    end
                    else
                    begin
                        stop = 1'b1;
                        priority case (mode_reg)
                            M_STR, M_KSTR:
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_UNTERM_STR, pos,
                                               1'b0};
                            M_STR_ESC, M_KSTR_ESC:
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_TRUNC_ESC,
                                               pos - 19'd1, 1'b0};
                            M_STR_HEX, M_KSTR_HEX:
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_TRUNC_U,
                                               pos - 19'(hcnt_reg), 1'b0};
                            M_LIT_T, M_LIT_F, M_LIT_N:
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_BAD_LIT,
                                               pos - 19'(lp_reg), 1'b0};
                            M_VALUE:
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_UNEXP_END, pos,
                                               1'b0};
                            M_ARR_FIRST:
                                if (lvl_reg > 5'(MAX_NEST))
                                    ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_TOO_DEEP, pos,
                                                   1'b0};
                                else if (vcnt_reg >= value_budget)
                                    ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_TOO_MANY_VAL,
                                                   pos, 1'b0};
                                else
                                    ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_UNEXP_END, pos,
                                                   1'b0};
                            M_ARR_NEXT:
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_EXP_COMMA_AR, pos,
                                               1'b0};
                            M_OBJ_FIRST, M_KEY:
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_EXP_STRING, pos,
                                               1'b0};
                            M_OBJ_NEXT:
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_EXP_COMMA_OB, pos,
                                               1'b0};
                            M_COLON:
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_EXP_COLON, pos,
                                               1'b0};
                            M_NUM_SIGN:
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_BAD_NUM, pos,
                                               1'b0};
                            default:
                                ev_next[n] = '{K_DONE, 8'd0, 61'sd0, ld, 5'd0, 19'd0, 1'b0};
                        endcase
                        n = n + 2'd1;
                    end
                end
                // new document
                mode_next = M_TOP; lvl_next = '0; acc_next = '0; dcnt_next = '0;
                neg_next = 1'b0; hex_next = '0; hcnt_next = '0; lp_next = '0;
                vcnt_next = '0; fin_next = 1'b0;
            end
            else if (!fin_reg)
            begin
                mode_t m;
                m = mode_reg;
                if (q_data.over)
                begin
                    ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_TOO_LARGE, pos, 1'b0};
                    n = n + 2'd1; stop = 1'b1;
                end
                // top-level value entry
                if (!stop && m == M_TOP)
                begin
                    if (lvl_reg > 5'(MAX_NEST))
                    begin
                        ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_TOO_DEEP, pos, 1'b0};
                        n = n + 2'd1; stop = 1'b1;
                    end
                    else if (vcnt_reg >= value_budget)
                    begin
                        ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_TOO_MANY_VAL, pos, 1'b0};
                        n = n + 2'd1; stop = 1'b1;
                    end
                    else
                    begin
                        vcnt_next = vcnt_reg + 16'd1;
                        m = M_VALUE;
                    end
                end
                // number continuation or termination
                if (!stop && m == M_NUM)
                begin
                    if (q_data.is_digit)
                    begin
                        stop = 1'b1;
                        if (dcnt_reg >= 5'(MAX_DIGITS))
                        begin
                            ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_NUM_LONG, pos, 1'b0};
                            n = n + 2'd1;
                        end
                        else
                        begin
                            dcnt_next = dcnt_reg + 5'd1;
                            nv = {acc_reg[56:0], 3'b000} + {acc_reg[58:0], 1'b0};
                            acc_next = nv + 60'(q_data.digit);
                        end
                    end
                    else if (b == "." || b == "e" || b == "E")
                    begin
                        ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_FLOAT, pos, 1'b0};
                        n = n + 2'd1; stop = 1'b1;
                    end
                    else
                    begin
                        ev_next[n] = '{K_INT, 8'd0,
                                       neg_reg ? -$signed({1'b0, acc_reg}) :
                                                 $signed({1'b0, acc_reg}),
                                       ld, 5'd0, 19'd0, 1'b0};
                        n = n + 2'd1;
                        acc_next = '0; dcnt_next = '0; neg_next = 1'b0;
                        if (lvl_reg == 5'd0)
                            m = M_AFTER;
                        else if (top_cnt >= container_limit)
                        begin
                            ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld,
                                           top_kind ? E_OBJ_FULL : E_ARR_FULL, pos, 1'b0};
                            n = n + 2'd1; stop = 1'b1;
                        end
                        else
                        begin
                            wr_en = 1'b1; wr_idx = top_idx; wr_kind = top_kind;
                            wr_cnt = top_cnt + 9'd1;
                            m = top_kind ? M_OBJ_NEXT : M_ARR_NEXT;
                        end
                    end
                end
                if (!stop)
                begin
                    k = (m >= M_KSTR);
                    priority case (m)
                        M_STR, M_KSTR:
                        begin
                            if (b == "\"")
                            begin
                                ev_next[n] = '{k ? K_KEY_END : K_STR_END, 8'd0, 61'sd0, ld,
                                               5'd0, 19'd0, 1'b0};
                                n = n + 2'd1;
                                if (k)
                                    m = M_COLON;
                                else if (lvl_reg == 5'd0)
                                    m = M_AFTER;
                                else if (top_cnt >= container_limit)
                                begin
                                    ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld,
                                                   top_kind ? E_OBJ_FULL : E_ARR_FULL,
                                                   pos + 19'd1, 1'b0};
                                    n = n + 2'd1; fin_next = 1'b1;
                                end
                                else
                                begin
                                    wr_en = 1'b1; wr_idx = top_idx; wr_kind = top_kind;
                                    wr_cnt = top_cnt + 9'd1;
                                    m = top_kind ? M_OBJ_NEXT : M_ARR_NEXT;
                                end
                            end
                            else if (b == "\\")
                                m = k ? M_KSTR_ESC : M_STR_ESC;
                            else if (b < 8'h20)
                            begin
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_CTRL_CHAR, pos,
                                               1'b0};
                                n = n + 2'd1; fin_next = 1'b1;
                            end
                            else
                            begin
                                ev_next[n] = '{k ? K_KEY_BYTE : K_STR_BYTE, b, 61'sd0, ld,
                                               5'd0, 19'd0, 1'b0};
                                n = n + 2'd1;
                            end
                        end
                        M_STR_ESC, M_KSTR_ESC:
                        begin
                            logic [7:0] c;
                            logic       ok;
                            c = b; ok = 1'b1;
                            m = k ? M_KSTR : M_STR;
                            unique case (b)
                                "\"", "\\", "/": c = b;
                                "b": c = 8'd8;
                                "f": c = 8'd12;
                                "n": c = 8'd10;
                                "r": c = 8'd13;
                                "t": c = 8'd9;
                                "u":
                                begin
                                    ok = 1'b0;
                                    m = k ? M_KSTR_HEX : M_STR_HEX;
                                    hex_next = '0; hcnt_next = '0;
                                end
                                default:
                                begin
                                    ok = 1'b0;
                                    ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_UNK_ESC,
                                                   pos + 19'd1, 1'b0};
                                    n = n + 2'd1; fin_next = 1'b1;
                                end
                            endcase
                            if (ok)
                            begin
                                ev_next[n] = '{k ? K_KEY_BYTE : K_STR_BYTE, c, 61'sd0, ld,
                                               5'd0, 19'd0, 1'b0};
                                n = n + 2'd1;
                            end
                        end
                        M_STR_HEX, M_KSTR_HEX:
                        begin
                            if (!q_data.hex_ok)
                            begin
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_BAD_HEX,
                                               pos - 19'(hcnt_reg), 1'b0};
                                n = n + 2'd1; fin_next = 1'b1;
                            end
                            else if (hcnt_reg != 3'd3)
                            begin
                                hex_next = {hex_reg[11:0], q_data.hex};
                                hcnt_next = hcnt_reg + 3'd1;
                            end
                            else
                            begin
                                v = {hex_reg[11:0], q_data.hex};
                                hex_next = '0; hcnt_next = '0;
                                m = k ? M_KSTR : M_STR;
                                if (v == 16'd0)
                                begin
                                    ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_NUL_ESC,
                                                   pos + 19'd1, 1'b0};
                                    n = n + 2'd1; fin_next = 1'b1;
                                end
                                else if (v >= 16'hD800 && v <= 16'hDFFF)
                                begin
                                    ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_SURROGATE,
                                                   pos + 19'd1, 1'b0};
                                    n = n + 2'd1; fin_next = 1'b1;
                                end
                                else if (v < 16'h80)
                                begin
                                    ev_next[0] = '{k ? K_KEY_BYTE : K_STR_BYTE, v[7:0],
                                                   61'sd0, ld, 5'd0, 19'd0, 1'b0};
                                    n = 2'd1;
                                end
                                else if (v < 16'h800)
                                begin
                                    ev_next[0] = '{k ? K_KEY_BYTE : K_STR_BYTE,
                                                   8'hC0 | {3'b0, v[10:6]}, 61'sd0, ld, 5'd0,
                                                   19'd0, 1'b0};
                                    ev_next[1] = '{k ? K_KEY_BYTE : K_STR_BYTE,
                                                   8'h80 | {2'b0, v[5:0]}, 61'sd0, ld, 5'd0,
                                                   19'd0, 1'b0};
                                    n = 2'd2;
                                end
                                else
                                begin
                                    ev_next[0] = '{k ? K_KEY_BYTE : K_STR_BYTE,
                                                   8'hE0 | {4'b0, v[15:12]}, 61'sd0, ld, 5'd0,
                                                   19'd0, 1'b0};
                                    ev_next[1] = '{k ? K_KEY_BYTE : K_STR_BYTE,
                                                   8'h80 | {2'b0, v[11:6]}, 61'sd0, ld, 5'd0,
                                                   19'd0, 1'b0};
                                    ev_next[2] = '{k ? K_KEY_BYTE : K_STR_BYTE,
                                                   8'h80 | {2'b0, v[5:0]}, 61'sd0, ld, 5'd0,
                                                   19'd0, 1'b0};
                                    n = 2'd3;
                                end
                            end
                        end
                        M_LIT_T, M_LIT_F, M_LIT_N:
                        begin
                            w = 2'(m - M_LIT_T);
                            if (lp_reg < lit_len(w) && b == lit_char(w, lp_reg))
                            begin
                                lp_next = lp_reg + 3'd1;
                                if (lp_reg + 3'd1 == lit_len(w))
                                begin
                                    lp_next = '0;
                                    ev_next[n] = '{4'(K_TRUE + w), 8'd0, 61'sd0, ld, 5'd0,
                                                   19'd0, 1'b0};
                                    n = n + 2'd1;
                                    if (lvl_reg == 5'd0)
                                        m = M_AFTER;
                                    else if (top_cnt >= container_limit)
                                    begin
                                        ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld,
                                                       top_kind ? E_OBJ_FULL : E_ARR_FULL,
                                                       pos + 19'd1, 1'b0};
                                        n = n + 2'd1; fin_next = 1'b1;
                                    end
                                    else
                                    begin
                                        wr_en = 1'b1; wr_idx = top_idx; wr_kind = top_kind;
                                        wr_cnt = top_cnt + 9'd1;
                                        m = top_kind ? M_OBJ_NEXT : M_ARR_NEXT;
                                    end
                                end
                            end
                            else
                            begin
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_BAD_LIT,
                                               pos - 19'(lp_reg), 1'b0};
                                n = n + 2'd1; fin_next = 1'b1;
                            end
                        end
                        M_NUM_SIGN:
                        begin
                            if (q_data.is_digit)
                            begin
                                acc_next = 60'(q_data.digit); dcnt_next = 5'd1; m = M_NUM;
                            end
                            else
                            begin
                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_BAD_NUM, pos,
                                               1'b0};
                                n = n + 2'd1; fin_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            logic sv;
                            logic cl;
                            logic clobj;
                            sv = 1'b0; cl = 1'b0; clobj = 1'b0;
                            if (!q_data.is_ws)
                            begin
                                priority case (m)
                                    M_VALUE: sv = 1'b1;
                                    M_ARR_FIRST:
                                        if (b == "]")
                                            cl = 1'b1;
                                        else if (lvl_reg > 5'(MAX_NEST))
                                        begin
                                            ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld,
                                                           E_TOO_DEEP, pos, 1'b0};
                                            n = n + 2'd1; fin_next = 1'b1;
                                        end
                                        else if (vcnt_reg >= value_budget)
                                        begin
                                            ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld,
                                                           E_TOO_MANY_VAL, pos, 1'b0};
                                            n = n + 2'd1; fin_next = 1'b1;
                                        end
                                        else
                                        begin
                                            vcnt_next = vcnt_reg + 16'd1;
                                            sv = 1'b1;
                                        end
                                    M_ARR_NEXT, M_COLON:
                                        if ((m == M_ARR_NEXT && b == ",") ||
                                            (m == M_COLON && b == ":"))
                                        begin
                                            if (lvl_reg > 5'(MAX_NEST))
                                            begin
                                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld,
                                                               E_TOO_DEEP, pos + 19'd1, 1'b0};
                                                n = n + 2'd1; fin_next = 1'b1;
                                            end
                                            else if (vcnt_reg >= value_budget)
                                            begin
                                                ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld,
                                                               E_TOO_MANY_VAL, pos + 19'd1,
                                                               1'b0};
                                                n = n + 2'd1; fin_next = 1'b1;
                                            end
                                            else
                                            begin
                                                vcnt_next = vcnt_reg + 16'd1;
                                                m = M_VALUE;
                                            end
                                        end
                                        else if (m == M_ARR_NEXT && b == "]")
                                            cl = 1'b1;
                                        else
                                        begin
                                            ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld,
                                                           (m == M_COLON) ? E_EXP_COLON :
                                                                            E_EXP_COMMA_AR,
                                                           pos, 1'b0};
                                            n = n + 2'd1; fin_next = 1'b1;
                                        end
                                    M_OBJ_FIRST, M_KEY:
                                        if (b == "}" && m == M_OBJ_FIRST)
                                        begin
                                            cl = 1'b1; clobj = 1'b1;
                                        end
                                        else if (b == "\"")
                                            m = M_KSTR;
                                        else
                                        begin
                                            ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld,
                                                           E_EXP_STRING, pos, 1'b0};
                                            n = n + 2'd1; fin_next = 1'b1;
                                        end
                                    M_OBJ_NEXT:
                                        if (b == ",")
                                            m = M_KEY;
                                        else if (b == "}")
                                        begin
                                            cl = 1'b1; clobj = 1'b1;
                                        end
                                        else
                                        begin
                                            ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld,
                                                           E_EXP_COMMA_OB, pos, 1'b0};
                                            n = n + 2'd1; fin_next = 1'b1;
                                        end
                                    default:
                                    begin
                                        ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_TRAILING,
                                                       pos, 1'b0};
                                        n = n + 2'd1; fin_next = 1'b1;
                                    end
                                endcase
                            end
                            // start of a value
                            if (sv)
                            begin
                                if (b == "{" || b == "[")
                                begin
                                    if (lvl_reg <= 5'(MAX_NEST))
                                    begin
                                        wr_en = 1'b1; wr_idx = SW'(lvl_reg);
                                        wr_kind = (b == "{"); wr_cnt = '0;
                                    end
                                    lvl_next = lvl_reg + 5'd1;
                                    ev_next[n] = '{(b == "{") ? K_OBJ_START : K_ARR_START,
                                                   8'd0, 61'sd0, lvl_reg + 5'd1, 5'd0, 19'd0,
                                                   1'b0};
                                    n = n + 2'd1;
                                    m = (b == "{") ? M_OBJ_FIRST : M_ARR_FIRST;
                                end
                                else if (b == "\"")
                                    m = M_STR;
                                else if (b == "t" || b == "f" || b == "n")
                                begin
                                    m = (b == "t") ? M_LIT_T : (b == "f") ? M_LIT_F : M_LIT_N;
                                    lp_next = 3'd1;
                                end
                                else if (b == "-")
                                begin
                                    neg_next = 1'b1; m = M_NUM_SIGN;
                                end
                                else if (q_data.is_digit)
                                begin
                                    acc_next = 60'(q_data.digit); dcnt_next = 5'd1; m = M_NUM;
                                end
                                else
                                begin
                                    ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, ld, E_UNEXP_CHAR,
                                                   pos, 1'b0};
                                    n = n + 2'd1; fin_next = 1'b1;
                                end
                            end
                            // close of a container and completion in the parent
                            if (cl)
                            begin
                                ev_next[n] = '{clobj ? K_OBJ_END : K_ARR_END, 8'd0, 61'sd0,
                                               ld, 5'd0, 19'd0, 1'b0};
                                n = n + 2'd1;
                                lvl_next = lvl_reg - 5'd1;
                                if (lvl_reg == 5'd1)
                                    m = M_AFTER;
                                else if (lvl_reg - 5'd2 > 5'(MAX_NEST))
                                begin
                                    ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, lvl_reg - 5'd1,
                                                   E_ARR_FULL, pos + 19'd1, 1'b0};
                                    n = n + 2'd1; fin_next = 1'b1;
                                end
                                else if (ecnt_reg[SW'(lvl_reg - 5'd2)] >= container_limit)
                                begin
                                    ev_next[n] = '{K_ERROR, 8'd0, 61'sd0, lvl_reg - 5'd1,
                                                   ckind_reg[SW'(lvl_reg - 5'd2)] ?
                                                       E_OBJ_FULL : E_ARR_FULL,
                                                   pos + 19'd1, 1'b0};
                                    n = n + 2'd1; fin_next = 1'b1;
                                end
                                else
                                begin
                                    wr_en = 1'b1; wr_idx = SW'(lvl_reg - 5'd2);
                                    wr_kind = ckind_reg[SW'(lvl_reg - 5'd2)];
                                    wr_cnt = ecnt_reg[SW'(lvl_reg - 5'd2)] + 9'd1;
                                    m = wr_kind ? M_OBJ_NEXT : M_ARR_NEXT;
                                end
                            end
                        end
                    endcase
                end
                if (stop && n != 2'd0 && ev_next[n - 2'd1].kind == K_ERROR)
                    fin_next = 1'b1;
                mode_next = m;
            end
            if (n != 2'd0)
                ev_next[n - 2'd1].last_of_run = 1'b1;
        end
        evn_next = n;
    end

    // container stack
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ckind_reg[wr_idx] <= wr_kind;
            ecnt_reg[wr_idx]  <= wr_cnt;
        end
    end

    // event buffer payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
            for (int i = 0; i < 3; i++)
                ev_reg[i] <= ev_next[i];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_TOP;  lvl_reg <= '0;  acc_reg <= '0;  dcnt_reg <= '0;
            neg_reg <= 1'b0;    hex_reg <= '0;  hcnt_reg <= '0; lp_reg <= '0;
            vcnt_reg <= '0;     fin_reg <= 1'b0;
            evn_reg <= '0;      evi_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next; lvl_reg <= lvl_next; acc_reg <= acc_next;
            dcnt_reg <= dcnt_next; neg_reg <= neg_next; hex_reg <= hex_next;
            hcnt_reg <= hcnt_next; lp_reg <= lp_next;   vcnt_reg <= vcnt_next;
            fin_reg <= fin_next;
            if (q_pop)
            begin
                evn_reg <= evn_next;
                evi_reg <= '0;
            end
            else if (busy && out_ready)
            begin
                if (evi_reg + 2'd1 == evn_reg)
                begin
                    evn_reg <= '0;
                    evi_reg <= '0;
                end
                else
                    evi_reg <= evi_reg + 2'd1;
            end
        end
    end
endmodule

[hdl/json_stream_tokenizer.sv]
`timescale 1ns / 1ps
// channel   dir   request                       fields
// in        in    one byte or end of document   cmd, data_byte
// out       out   one token event               kind .. last_of_run
// cfg       in    register write                index, data
//
// one byte per cycle while each byte yields at most one event and the output is
// ready; a byte that yields two or three events holds the back end until the
// output has taken them all (the event buffer hands out one event at a time).
// a four-entry queue separates byte classification from the parser, so the
// input keeps flowing while the output stalls, until the queue is full.
// rst_n clears all control state at once; no clearing pass is needed.
module json_stream_tokenizer #(
    parameter int MAX_NEST   = jst_pkg::MaxNestDefault,
    parameter int MAX_DIGITS = jst_pkg::MaxDigitsDefault
) (
    input  logic     clk,
    input  logic     rst_n,
    jst_in_if.sink   in,
    jst_out_if.source out,
    jst_cfg_if.sink  cfg
);
    import jst_pkg::*;

    logic [15:0] budget_reg;
    logic [8:0]  climit_reg;
    logic [18:0] ilimit_reg;

    logic        q_push, q_full, q_pop, q_empty;
    tok_t        q_wdata, q_rdata;
    evt_t        evt;

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BudgetReset;
            climit_reg <= ContLimReset;
            ilimit_reg <= InLimReset;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_VALUE_BUDGET:    budget_reg <= cfg.data[15:0];
                REG_CONTAINER_LIMIT: climit_reg <= cfg.data[8:0];
                REG_INPUT_LIMIT:     ilimit_reg <= cfg.data;
                default:             ;
            endcase
        end
    end

    jst_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in.valid),
        .in_ready    (in.ready),
        .in_cmd      (in.cmd),
        .in_data     (in.data_byte),
        .input_limit (ilimit_reg),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_full      (q_full)
    );

    jst_queue #(.DEPTH(4)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    jst_back #(.MAX_NEST(MAX_NEST), .MAX_DIGITS(MAX_DIGITS)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_data          (q_rdata),
        .q_pop           (q_pop),
        .value_budget    (budget_reg),
        .container_limit (climit_reg),
        .out_valid       (out.valid),
        .out_ready       (out.ready),
        .out_evt         (evt)
    );

    assign out.kind        = evt.kind;
    assign out.text_byte   = evt.text_byte;
    assign out.int_value   = evt.int_value;
    assign out.nest_depth  = evt.nest_depth;
    assign out.error_code  = evt.error_code;
    assign out.byte_offset = evt.byte_offset;
    assign out.last_of_run = evt.last_of_run;

    // error events carry a code in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && out.kind == K_ERROR |-> out.error_code <= 5'd23)
        else $error("error code out of range");

    // non-error events carry no offset
    assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && out.kind != K_ERROR |-> out.byte_offset == 19'd0)
        else $error("offset on non-error event");

    // queue never pushed while full
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue overflow");
endmodule

[tb/json_stream_tokenizer_tb.sv]
`timescale 1ns / 1ps
module json_stream_tokenizer_tb;
    import jst_pkg::*;

    // expected token events and the tokenizer state that produces them
    class token_scoreboard;
        int unsigned budget, cont_lim, in_lim;
        bit          open_is_obj [17];
        int unsigned open_count [17];
        int unsigned depth, mode, ndigits, nhex, lit_pos, nvalues, offset;
        logic [63:0] num_acc;
        logic [15:0] hex_acc;
        bit          num_neg, stuck;
        evt_t        pending_q[$];
        evt_t        step_q[$];
        int          errors;
        string       lit_words[3];

        function new();
            lit_words = '{"true", "false", "null"};
            for (int k = 0; k < 17; k++)
            begin
                open_is_obj[k] = 0;
                open_count[k] = 0;
            end
            budget = BudgetReset;
            cont_lim = ContLimReset;
            in_lim = InLimReset;
            errors = 0;
            clear_doc();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void set_reg(reg_idx_t idx, logic [18:0] v);
            case (idx)
                REG_VALUE_BUDGET:    budget = v[15:0];
                REG_CONTAINER_LIMIT: cont_lim = v[8:0];
                REG_INPUT_LIMIT:     in_lim = v;
                default: ;
            endcase
        endfunction

        function void clear_doc();
            depth = 0;
            mode = M_TOP;
            num_acc = 0;
            ndigits = 0;
            num_neg = 0;
            hex_acc = 0;
            nhex = 0;
            lit_pos = 0;
            nvalues = 0;
            offset = 0;
            stuck = 0;
        endfunction

        function void push_evt(kind_t k, logic [7:0] t, logic [63:0] v, err_t e,
                               int unsigned off);
            evt_t x;
            if (step_q.size() >= 3)
                return;
            x.kind = k;
            x.text_byte = t;
            x.int_value = v[60:0];
            x.nest_depth = depth[4:0];
            x.error_code = e;
            x.byte_offset = off[18:0];
            x.last_of_run = 1'b0;
            step_q = {step_q, x};
        endfunction

        function bit raise(err_t e, int unsigned off);
            push_evt(K_ERROR, 8'd0, 64'd0, e, off);
            stuck = 1;
            return 0;
        endfunction

        function bit admit_value(int unsigned off);
            if (depth > MaxNestDefault)
                return raise(E_TOO_DEEP, off);
            if (nvalues >= budget)
                return raise(E_TOO_MANY_VAL, off);
            nvalues++;
            return 1;
        endfunction

        function bit close_element(int unsigned off);
            int unsigned idx;
            if (depth == 0)
            begin
                mode = M_AFTER;
                return 1;
            end
            idx = depth - 1;
            if (idx > MaxNestDefault)
                return raise(E_ARR_FULL, off);
            if (open_count[idx] >= cont_lim)
                return raise(open_is_obj[idx] ? E_OBJ_FULL : E_ARR_FULL, off);
            open_count[idx]++;
            mode = open_is_obj[idx] ? M_OBJ_NEXT : M_ARR_NEXT;
            return 1;
        endfunction

        function bit emit_number(int unsigned off);
            logic [63:0] v;
            v = num_neg ? (64'd0 - num_acc) : num_acc;
            push_evt(K_INT, 8'd0, v, E_BAD_LIT, 0);
            num_acc = 0;
            ndigits = 0;
            num_neg = 0;
            return close_element(off);
        endfunction

        function void open_level(bit obj);
            if (depth <= MaxNestDefault)
            begin
                open_is_obj[depth] = obj;
                open_count[depth] = 0;
            end
            depth++;
            push_evt(obj ? K_OBJ_START : K_ARR_START, 8'd0, 64'd0, E_BAD_LIT, 0);
            mode = obj ? M_OBJ_FIRST : M_ARR_FIRST;
        endfunction

        function void close_level(bit obj, int unsigned pos);
            push_evt(obj ? K_OBJ_END : K_ARR_END, 8'd0, 64'd0, E_BAD_LIT, 0);
            if (depth > 0)
                depth--;
            void'(close_element(pos + 1));
        endfunction

        function void begin_value(logic [7:0] b, int unsigned pos);
            if (b == "{")
                open_level(1);
            else if (b == "[")
                open_level(0);
            else if (b == "\"")
                mode = M_STR;
            else if (b == "t" || b == "f" || b == "n")
            begin
                mode = (b == "t") ? M_LIT_T : (b == "f") ? M_LIT_F : M_LIT_N;
                lit_pos = 1;
            end
            else if (b == "-")
            begin
                num_neg = 1;
                mode = M_NUM_SIGN;
            end
            else if (b >= "0" && b <= "9")
            begin
                num_acc = b - "0";
                ndigits = 1;
                mode = M_NUM;
            end
            else
                void'(raise(E_UNEXP_CHAR, pos));
        endfunction

        function void push_utf8(kind_t k, int unsigned v);
            if (v < 'h80)
                push_evt(k, v[7:0], 64'd0, E_BAD_LIT, 0);
            else if (v < 'h800)
            begin
                push_evt(k, 8'(8'hC0 | (v >> 6)), 64'd0, E_BAD_LIT, 0);
                push_evt(k, 8'(8'h80 | (v & 'h3F)), 64'd0, E_BAD_LIT, 0);
            end
            else
            begin
                push_evt(k, 8'(8'hE0 | (v >> 12)), 64'd0, E_BAD_LIT, 0);
                push_evt(k, 8'(8'h80 | ((v >> 6) & 'h3F)), 64'd0, E_BAD_LIT, 0);
                push_evt(k, 8'(8'h80 | (v & 'h3F)), 64'd0, E_BAD_LIT, 0);
            end
        endfunction

        function int hex_digit(logic [7:0] b);
            if (b >= "0" && b <= "9")
                return b - "0";
            if (b >= "a" && b <= "f")
                return b - "a" + 10;
            if (b >= "A" && b <= "F")
                return b - "A" + 10;
            return -1;
        endfunction

        // string and key bodies, escapes and \u sequences
        function void string_byte(logic [7:0] b, int unsigned pos);
            int unsigned base, sub, v;
            bit          is_key;
            kind_t       bk;
            logic [7:0]  c;
            int          d;
            base = (mode >= M_KSTR) ? M_KSTR : M_STR;
            is_key = (base == M_KSTR);
            bk = is_key ? K_KEY_BYTE : K_STR_BYTE;
            sub = mode - base;
            if (sub == 0)
            begin
                if (b == "\"")
                begin
                    push_evt(is_key ? K_KEY_END : K_STR_END, 8'd0, 64'd0, E_BAD_LIT, 0);
                    if (is_key)
                        mode = M_COLON;
                    else
                        void'(close_element(pos + 1));
                end
                else if (b == "\\")
                    mode = base + 1;
                else if (b < 8'h20)
                    void'(raise(E_CTRL_CHAR, pos));
                else
                    push_evt(bk, b, 64'd0, E_BAD_LIT, 0);
            end
            else if (sub == 1)
            begin
                mode = base;
                case (b)
                    "\"", "\\", "/": c = b;
                    "b": c = 8'd8;
                    "f": c = 8'd12;
                    "n": c = 8'd10;
                    "r": c = 8'd13;
                    "t": c = 8'd9;
                    "u":
                    begin
                        mode = base + 2;
                        hex_acc = 0;
                        nhex = 0;
                        return;
                    end
                    default:
                    begin
                        void'(raise(E_UNK_ESC, pos + 1));
                        return;
                    end
                endcase
                push_evt(bk, c, 64'd0, E_BAD_LIT, 0);
            end
            else
            begin
                d = hex_digit(b);
                if (d < 0)
                begin
                    void'(raise(E_BAD_HEX, pos - nhex));
                    return;
                end
                hex_acc = {hex_acc[11:0], d[3:0]};
                nhex++;
                if (nhex < 4)
                    return;
                v = hex_acc;
                hex_acc = 0;
                nhex = 0;
                mode = base;
                if (v == 0)
                    void'(raise(E_NUL_ESC, pos + 1));
                else if (v >= 'hD800 && v <= 'hDFFF)
                    void'(raise(E_SURROGATE, pos + 1));
                else
                    push_utf8(bk, v);
            end
        endfunction

        function void doc_byte(logic [7:0] b, int unsigned pos);
            int unsigned w;
            bit          digit, blank;
            digit = (b >= "0" && b <= "9");
            blank = (b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D);
            if (mode == M_TOP)
            begin
                if (!admit_value(pos))
                    return;
                mode = M_VALUE;
            end
            if (mode == M_NUM)
            begin
                if (digit)
                begin
                    if (ndigits >= MaxDigitsDefault)
                    begin
                        void'(raise(E_NUM_LONG, pos));
                        return;
                    end
                    ndigits++;
                    num_acc = num_acc * 10 + (b - "0");
                    return;
                end
                if (b == "." || b == "e" || b == "E")
                begin
                    void'(raise(E_FLOAT, pos));
                    return;
                end
                if (!emit_number(pos))
                    return;
            end
            if (mode >= M_STR && mode < M_NUM_SIGN)
            begin
                string_byte(b, pos);
                return;
            end
            if (mode >= M_LIT_T && mode < M_AFTER)
            begin
                w = mode - M_LIT_T;
                if (lit_pos < lit_words[w].len() && b == lit_words[w][lit_pos])
                begin
                    lit_pos++;
                    if (lit_pos == lit_words[w].len())
                    begin
                        lit_pos = 0;
                        push_evt(kind_t'(K_TRUE + w), 8'd0, 64'd0, E_BAD_LIT, 0);
                        void'(close_element(pos + 1));
                    end
                end
                else
                    void'(raise(E_BAD_LIT, pos - lit_pos));
                return;
            end
            if (mode == M_NUM_SIGN)
            begin
                if (digit)
                begin
                    num_acc = b - "0";
                    ndigits = 1;
                    mode = M_NUM;
                end
                else
                    void'(raise(E_BAD_NUM, pos));
                return;
            end
            if (blank)
                return;
            case (mode)
                M_VALUE: begin_value(b, pos);
                M_ARR_FIRST:
                    if (b == "]")
                        close_level(0, pos);
                    else if (admit_value(pos))
                        begin_value(b, pos);
                M_ARR_NEXT:
                    if (b == ",")
                    begin
                        if (admit_value(pos + 1))
                            mode = M_VALUE;
                    end
                    else if (b == "]")
                        close_level(0, pos);
                    else
                        void'(raise(E_EXP_COMMA_AR, pos));
                M_OBJ_FIRST, M_KEY:
                    if (b == "}" && mode == M_OBJ_FIRST)
                        close_level(1, pos);
                    else if (b == "\"")
                        mode = M_KSTR;
                    else
                        void'(raise(E_EXP_STRING, pos));
                M_OBJ_NEXT:
                    if (b == ",")
                        mode = M_KEY;
                    else if (b == "}")
                        close_level(1, pos);
                    else
                        void'(raise(E_EXP_COMMA_OB, pos));
                M_COLON:
                    if (b == ":")
                    begin
                        if (admit_value(pos + 1))
                            mode = M_VALUE;
                    end
                    else
                        void'(raise(E_EXP_COLON, pos));
                default: void'(raise(E_TRAILING, pos));
            endcase
        endfunction

        function void doc_end();
            int unsigned pos;
            pos = offset;
            if (mode == M_TOP)
            begin
                if (!admit_value(pos))
                    return;
                mode = M_VALUE;
            end
            if (mode == M_NUM && !emit_number(pos))
                return;
            if (mode >= M_STR && mode < M_NUM_SIGN)
            begin
                case ((mode - M_STR) % 3)
                    0: void'(raise(E_UNTERM_STR, pos));
                    1: void'(raise(E_TRUNC_ESC, pos - 1));
                    default: void'(raise(E_TRUNC_U, pos - nhex));
                endcase
                return;
            end
            if (mode >= M_LIT_T && mode < M_AFTER)
            begin
                void'(raise(E_BAD_LIT, pos - lit_pos));
                return;
            end
            case (mode)
                M_VALUE: void'(raise(E_UNEXP_END, pos));
                M_ARR_FIRST: if (admit_value(pos)) void'(raise(E_UNEXP_END, pos));
                M_ARR_NEXT: void'(raise(E_EXP_COMMA_AR, pos));
                M_OBJ_FIRST, M_KEY: void'(raise(E_EXP_STRING, pos));
                M_OBJ_NEXT: void'(raise(E_EXP_COMMA_OB, pos));
                M_COLON: void'(raise(E_EXP_COLON, pos));
                M_NUM_SIGN: void'(raise(E_BAD_NUM, pos));
                default: push_evt(K_DONE, 8'd0, 64'd0, E_BAD_LIT, 0);
            endcase
        endfunction

        // accepted request: work out its events
        function void note_request(logic c, logic [7:0] b);
            int unsigned pos;
            step_q.delete();
            if (c)
            begin
                if (!stuck)
                    doc_end();
                clear_doc();
            end
            else if (!stuck)
            begin
                pos = offset;
                if (pos >= in_lim)
                    void'(raise(E_TOO_LARGE, pos));
                else
                begin
                    offset = (pos + 1) & 'h7FFFF;
                    doc_byte(b, pos);
                end
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last_of_run = 1'b1;
            pending_q = {pending_q, step_q};
        endfunction

        task check_event(evt_t got);
            evt_t w;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected event kind %0d", got.kind));
                return;
            end
            w = pending_q.pop_front();
            if (got.kind !== w.kind)
                report($sformatf("kind %0d, want %0d", got.kind, w.kind));
            if (got.text_byte !== w.text_byte)
                report($sformatf("text_byte %h, want %h", got.text_byte, w.text_byte));
            if (got.int_value !== w.int_value)
                report($sformatf("int_value %0d, want %0d", got.int_value, w.int_value));
            if (got.nest_depth !== w.nest_depth)
                report($sformatf("nest_depth %0d, want %0d", got.nest_depth, w.nest_depth));
            if (got.error_code !== w.error_code)
                report($sformatf("error_code %0d, want %0d", got.error_code, w.error_code));
            if (got.byte_offset !== w.byte_offset)
                report($sformatf("byte_offset %0d, want %0d", got.byte_offset,
                                 w.byte_offset));
            if (got.last_of_run !== w.last_of_run)
                report($sformatf("last_of_run %b, want %b", got.last_of_run, w.last_of_run));
        endtask
    endclass

    logic clk;
    logic rst_n;

    jst_in_if  in_if();
    jst_out_if out_if();
    jst_cfg_if cfg_if();

    json_stream_tokenizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_if),
        .out   (out_if),
        .cfg   (cfg_if)
    );

    token_scoreboard sb = new();
    logic [8:0]      doc_q[$];
    bit              calm;
    int              quiet_cycles;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // result side: random stalls, checked on every accepted event
    always @(posedge clk)
    begin
        if (out_if.valid && out_if.ready)
            sb.check_event('{kind: out_if.kind, text_byte: out_if.text_byte,
                             int_value: out_if.int_value, nest_depth: out_if.nest_depth,
                             error_code: out_if.error_code, byte_offset: out_if.byte_offset,
                             last_of_run: out_if.last_of_run});
        out_if.ready <= calm || ($urandom_range(0, 99) >= 16);
    end

    // watchdog on cycles with no request accepted anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000)
        begin
            $display("[json_stream_tokenizer] ERROR");
            $finish;
        end
    end

    task automatic send_byte(logic c, logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd <= c;
        in_if.data_byte <= b;
        do
            @(posedge clk);
        while (!in_if.ready);
        sb.note_request(c, b);
    endtask

    task automatic send_queue();
        logic [8:0] item;
        while (doc_q.size() > 0)
        begin
            item = doc_q.pop_front();
            send_byte(item[8], item[7:0]);
        end
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [18:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.set_reg(idx, v);
    endtask

    task automatic set_limits(int unsigned bud, int unsigned cl, int unsigned il);
        drain();
        write_reg(REG_VALUE_BUDGET, 19'(bud));
        write_reg(REG_CONTAINER_LIMIT, 19'(cl));
        write_reg(REG_INPUT_LIMIT, 19'(il));
        cfg_if.valid <= 1'b0;
    endtask

    function automatic void add_item(logic [8:0] item);
        doc_q = {doc_q, item};
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_item({1'b0, s[i]});
    endfunction

    function automatic void put_doc(string s);
        put_text(s);
        add_item({1'b1, 8'd0});
    endfunction

    function automatic void put_blank();
        logic [7:0] ws[4] = '{" ", 8'h09, 8'h0A, 8'h0D};
        if ($urandom_range(0, 9) == 0)
            add_item({1'b0, ws[$urandom_range(0, 3)]});
    endfunction

    function automatic logic [7:0] hex_char(int unsigned v);
        string low = "0123456789abcdef";
        string up = "0123456789ABCDEF";
        return $urandom_range(0, 1) ? up[v] : low[v];
    endfunction

    function automatic void gen_string();
        int unsigned n, v;
        string       esc = "\"\\/bfnrt";
        add_item({1'b0, 8'h22});
        n = $urandom_range(0, 4);
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0: add_item({1'b0, 8'($urandom_range(8'h80, 8'hFF))});
                1:
                begin
                    add_item({1'b0, 8'h5C});
                    add_item({1'b0, esc[$urandom_range(0, 7)]});
                end
                2:
                begin
                    case ($urandom_range(0, 3))
                        0: v = $urandom_range(1, 'h7F);
                        1: v = $urandom_range('h80, 'h7FF);
                        2: v = $urandom_range('hE000, 'hFFFF);
                        default: v = $urandom_range('h800, 'hD7FF);
                    endcase
                    put_text("\\u");
                    for (int s = 12; s >= 0; s -= 4)
                        add_item({1'b0, hex_char((v >> s) & 'hF)});
                end
                default:
                begin
                    v = $urandom_range(8'h20, 8'h7E);
                    if (v == 8'h22 || v == 8'h5C)
                        v = "a";
                    add_item({1'b0, 8'(v)});
                end
            endcase
        end
        add_item({1'b0, 8'h22});
    endfunction

    function automatic void gen_value(int unsigned lvl);
        int unsigned n, sel;
        sel = (lvl >= 4) ? $urandom_range(2, 6) : $urandom_range(0, 6);
        put_blank();
        case (sel)
            0, 1:
            begin
                add_item({1'b0, (sel == 0) ? 8'h7B : 8'h5B});
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0)
                        add_item({1'b0, 8'h2C});
                    if (sel == 0)
                    begin
                        put_blank();
                        gen_string();
                        put_blank();
                        add_item({1'b0, 8'h3A});
                    end
                    gen_value(lvl + 1);
                end
                put_blank();
                add_item({1'b0, (sel == 0) ? 8'h7D : 8'h5D});
            end
            2: gen_string();
            3, 4:
            begin
                if ($urandom_range(0, 2) == 0)
                    add_item({1'b0, 8'h2D});
                n = ($urandom_range(0, 7) == 0) ? 18 : $urandom_range(1, 4);
                repeat (n)
                    add_item({1'b0, 8'("0" + $urandom_range(0, 9))});
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: put_text("true");
                    1: put_text("false");
                    default: put_text("null");
                endcase
            end
        endcase
        put_blank();
    endfunction

    // one random document, sometimes damaged, sometimes deeply nested
    function automatic void gen_doc();
        int unsigned start, len, r;
        start = doc_q.size();
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(15, 18))
                add_item({1'b0, 8'h5B});
        gen_value(0);
        len = doc_q.size() - start;
        r = $urandom_range(0, 99);
        if (r < 12)
            doc_q[start + $urandom_range(0, len - 1)] = {1'b0, 8'($urandom_range(0, 255))};
        else if (r < 18 && len > 1)
            repeat ($urandom_range(1, len - 1))
                void'(doc_q.pop_back());
        else if (r < 22)
            add_item({1'b0, 8'($urandom_range(0, 255))});
        add_item({1'b1, 8'($urandom_range(0, 255))});
    endfunction

    task automatic random_phase(int unsigned n_bytes);
        int unsigned sent;
        sent = 0;
        while (sent < n_bytes)
        begin
            gen_doc();
            sent += doc_q.size();
            send_queue();
            // hold back until every event of the document is out
            if ($urandom_range(0, 9) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        calm = 1'b0;
        in_if.valid = 1'b0;
        in_if.cmd = 1'b0;
        in_if.data_byte = 8'd0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_VALUE_BUDGET;
        cfg_if.data = 19'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed documents: each event kind and each error reason that needs no lowered limit, no idling
        calm = 1'b1;
        put_doc("{\"a\":[1,-20,true,false,null],\"b\":{}}");
        put_doc("[\"\\\"\\\\\\/\\b\\f\\n\\r\\t\\u0041\\u00e9\\u20AC\"]");
        put_doc("-999999999999999999");
        put_doc("999999999999999999 ");
        put_doc("1234567890123456789");
        put_doc("[1.5]");
        put_doc("tru");
        put_doc("nul1");
        put_doc("\"\\u0000\"");
        put_doc("\"\\uD800\"");
        put_doc("\"\\x\"");
        put_doc("\"\\u12G4\"");
        put_doc("\"ab");
        put_doc("\"\\");
        put_doc("\"\\u12");
        put_doc("{1}");
        put_doc("{\"a\" 1}");
        put_doc("{\"a\":1 2}");
        put_doc("{\"k\":1,");
        put_doc("[1 2]");
        put_doc("-x");
        put_doc("1 x");
        put_doc("@");
        put_doc("");
        put_doc("[");
        put_doc("[[[[[[[[[[[[[[[[[1]");
        put_text("\"");
        add_item({1'b0, 8'h01});
        put_doc("\"");
        put_doc("\"\xff\"");
        send_queue();
        calm = 1'b0;
        random_phase(15);

        // lowest limits
        set_limits(1, 1, 1);
        put_doc("1");
        put_doc("[1]");
        put_doc("12");
        send_queue();
        set_limits(2, 1, 40);
        put_doc("[1,2]");
        put_doc("{\"a\":1,\"b\":2}");
        put_doc("[1,2,3]");
        send_queue();
        random_phase(10);

        // highest value budget, container and input limits at their reset values
        set_limits(65535, 256, 262144);
        random_phase(15);

        // middling random limits
        set_limits($urandom_range(3, 12), $urandom_range(1, 4), $urandom_range(8, 60));
        random_phase(10);

        drain();
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("[json_stream_tokenizer] OK");
        else
            $display("[json_stream_tokenizer] ERROR");
        $finish;
    end
endmodule

[files.f]
hdl/jst_pkg.sv
hdl/jst_if.sv
hdl/jst_front.sv
hdl/jst_queue.sv
hdl/jst_back.sv
hdl/json_stream_tokenizer.sv
tb/json_stream_tokenizer_tb.sv
